// ===== rtl/ppl_pkg.sv =====
package ppl_pkg;

    localparam int VW          = 28;   // vectoring datapath width
    localparam int RW          = 36;   // rotation datapath width
    localparam int FW          = 36;   // width ahead of the final rounding
    localparam int AW          = 32;   // angle width, fraction of a turn
    localparam int DW          = 32;   // dividend and quotient width
    localparam int MAX_SOURCES = 8;

    localparam logic signed [AW-1:0] QUARTER_TURN = 32'sh4000_0000;
    localparam logic [AW-1:0]        HALF_TURN    = 32'h8000_0000;
    localparam logic [29:0]          INV_GAIN     = 30'd652032874;

    localparam logic [2:0] KIND_INDEP    = 3'd0;
    localparam logic [2:0] KIND_CIRCULAR = 3'd1;
    localparam logic [2:0] KIND_FIX_RAD  = 3'd2;
    localparam logic [2:0] KIND_FIX_ANG  = 3'd3;
    localparam logic [2:0] KIND_FIXED    = 3'd4;
    localparam logic [2:0] KIND_MIRROR_X = 3'd5;
    localparam logic [2:0] KIND_MIRROR_Y = 3'd6;
    localparam logic [2:0] KIND_DELTA    = 3'd7;

    localparam logic [2:0] REG_LINK_KIND  = 3'd0;
    localparam logic [2:0] REG_ROTATION   = 3'd1;
    localparam logic [2:0] REG_RATIO      = 3'd2;
    localparam logic [2:0] REG_FIX_RADIUS = 3'd3;
    localparam logic [2:0] REG_BASE_ANGLE = 3'd4;
    localparam logic [2:0] REG_ANGLE_STEP = 3'd5;
    localparam logic [2:0] REG_REF_X      = 3'd6;
    localparam logic [2:0] REG_REF_Y      = 3'd7;

    typedef struct packed {
        logic               inv;
        logic signed [15:0] px;
        logic signed [15:0] py;
        logic [2:0]         rank;
    } t_ctx;

    typedef struct packed {
        logic signed [VW-1:0] x;
        logic signed [VW-1:0] y;
        logic [AW-1:0]        z;
        logic                 zero;
    } t_vec;

    typedef struct packed {
        logic [DW-1:0] na;
        logic [DW-1:0] nb;
        logic [15:0]   ra;
        logic [15:0]   rb;
        logic          sa;
        logic          sb;
    } t_div;

    typedef struct packed {
        t_ctx                 ctx;
        logic [AW-1:0]        ang;
        logic signed [RW-1:0] mul;
    } t_side;

    typedef struct packed {
        logic signed [RW-1:0] x;
        logic signed [RW-1:0] y;
        logic signed [AW-1:0] z;
    } t_rot;

    typedef struct packed {
        logic               direct;
        logic               pmul;
        logic signed [17:0] dx;
        logic signed [17:0] dy;
    } t_post;

    function automatic logic [AW-1:0] atan_turn(input int idx);
        logic [AW-1:0] v;
        case (idx)
            0:       v = 32'h2000_0000;
            1:       v = 32'h12E4_051E;
            2:       v = 32'h09FB_385B;
            3:       v = 32'h0511_11D4;
            4:       v = 32'h028B_0D43;
            5:       v = 32'h0145_D7E1;
            6:       v = 32'h00A2_F61E;
            7:       v = 32'h0051_7C55;
            8:       v = 32'h0028_BE53;
            9:       v = 32'h0014_5F2F;
            10:      v = 32'h000A_2F98;
            11:      v = 32'h0005_17CC;
            12:      v = 32'h0002_8BE6;
            13:      v = 32'h0001_45F3;
            14:      v = 32'h0000_A2FA;
            15:      v = 32'h0000_517D;
            16:      v = 32'h0000_28BE;
            17:      v = 32'h0000_145F;
            18:      v = 32'h0000_0A30;
            19:      v = 32'h0000_0518;
            20:      v = 32'h0000_028C;
            21:      v = 32'h0000_0146;
            22:      v = 32'h0000_00A3;
            23:      v = 32'h0000_0051;
            default: v = '0;
        endcase
        return v;
    endfunction

endpackage

// ===== rtl/ppl_vec_cell.sv =====
module ppl_vec_cell #(
    parameter int IDX = 0
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_adv,
    input  logic          i_valid,
    input  ppl_pkg::t_vec i_vec,
    input  ppl_pkg::t_ctx i_ctx,
    output logic          o_valid,
    output ppl_pkg::t_vec o_vec,
    output ppl_pkg::t_ctx o_ctx
);
    import ppl_pkg::*;

    logic signed [VW-1:0] w_x, w_y, w_dx, w_dy;
    t_vec n_vec;
    t_vec r_vec;
    t_ctx r_ctx;
    logic r_valid;

    always_comb begin
        w_x   = i_vec.x;
        w_y   = i_vec.y;
        w_dx  = w_y >>> IDX;
        w_dy  = w_x >>> IDX;
        n_vec = i_vec;
        if (!w_y[VW-1]) begin
            n_vec.x = w_x + w_dx;
            n_vec.y = w_y - w_dy;
            n_vec.z = i_vec.z + atan_turn(IDX);
        end else begin
            n_vec.x = w_x - w_dx;
            n_vec.y = w_y + w_dy;
            n_vec.z = i_vec.z - atan_turn(IDX);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_adv) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r_vec <= n_vec;
            r_ctx <= i_ctx;
        end
    end

    assign o_valid = r_valid;
    assign o_vec   = r_vec;
    assign o_ctx   = r_ctx;

endmodule

// ===== rtl/ppl_div_cell.sv =====
module ppl_div_cell (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_adv,
    input  logic [15:0]    i_den,
    input  logic           i_valid,
    input  ppl_pkg::t_div  i_div,
    input  ppl_pkg::t_side i_side,
    output logic           o_valid,
    output ppl_pkg::t_div  o_div,
    output ppl_pkg::t_side o_side
);
    import ppl_pkg::*;

    logic [16:0] w_ta, w_tb, w_den;
    t_div  n_div;
    t_div  r_div;
    t_side r_side;
    logic  r_valid;

    // One quotient bit per cell in each of the two lanes; each quotient shifts into its dividend register.
    always_comb begin
        w_den = {1'b0, i_den};
        w_ta  = {i_div.ra, i_div.na[DW-1]};
        w_tb  = {i_div.rb, i_div.nb[DW-1]};
        n_div = i_div;
        if (w_ta >= w_den) begin
            n_div.ra = 16'(w_ta - w_den);
            n_div.na = {i_div.na[DW-2:0], 1'b1};
        end else begin
            n_div.ra = w_ta[15:0];
            n_div.na = {i_div.na[DW-2:0], 1'b0};
        end
        if (w_tb >= w_den) begin
            n_div.rb = 16'(w_tb - w_den);
            n_div.nb = {i_div.nb[DW-2:0], 1'b1};
        end else begin
            n_div.rb = w_tb[15:0];
            n_div.nb = {i_div.nb[DW-2:0], 1'b0};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_adv) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r_div  <= n_div;
            r_side <= i_side;
        end
    end

    assign o_valid = r_valid;
    assign o_div   = r_div;
    assign o_side  = r_side;

endmodule

// ===== rtl/ppl_rot_cell.sv =====
module ppl_rot_cell #(
    parameter int IDX = 0
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_adv,
    input  logic           i_valid,
    input  ppl_pkg::t_rot  i_rot,
    input  ppl_pkg::t_post i_post,
    output logic           o_valid,
    output ppl_pkg::t_rot  o_rot,
    output ppl_pkg::t_post o_post
);
    import ppl_pkg::*;

    logic signed [RW-1:0] w_x, w_y, w_dx, w_dy;
    t_rot  n_rot;
    t_rot  r_rot;
    t_post r_post;
    logic  r_valid;

    always_comb begin
        w_x   = i_rot.x;
        w_y   = i_rot.y;
        w_dx  = w_y >>> IDX;
        w_dy  = w_x >>> IDX;
        n_rot = i_rot;
        if (!i_rot.z[AW-1]) begin
            n_rot.x = w_x - w_dx;
            n_rot.y = w_y + w_dy;
            n_rot.z = i_rot.z - $signed(atan_turn(IDX));
        end else begin
            n_rot.x = w_x + w_dx;
            n_rot.y = w_y - w_dy;
            n_rot.z = i_rot.z + $signed(atan_turn(IDX));
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_adv) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r_rot  <= n_rot;
            r_post <= i_post;
        end
    end

    assign o_valid = r_valid;
    assign o_rot   = r_rot;
    assign o_post  = r_post;

endmodule

// ===== rtl/planar_position_link_transform.sv =====
// Maps one signed Q2.14 source position per transaction to its linked position under one
// of eight link kinds selected by the register file, forward or inverse per transaction.
// The datapath is a fixed pipeline: a vectoring CORDIC chain of CORDIC_STAGES cells, a
// gain stage, a 32-cell restoring divider chain, a rotation CORDIC chain of CORDIC_STAGES
// cells, two gain stages, a ratio stage and the output register. One transaction is
// accepted every cycle; the whole pipeline holds while the output register is stalled.
// Registers must only be written when no transaction is in flight.
module planar_position_link_transform #(
    parameter int CORDIC_STAGES = 16
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [4:0]         paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready,
    input  logic               i_valid,
    output logic               o_stall,
    input  logic               i_mode,
    input  logic signed [15:0] i_pos_x,
    input  logic signed [15:0] i_pos_y,
    input  logic [2:0]         i_slot_rank,
    output logic               o_valid,
    input  logic               i_stall,
    output logic signed [15:0] o_out_x,
    output logic signed [15:0] o_out_y,
    output logic               o_clipped
);
    import ppl_pkg::*;

    // Register file.
    logic [2:0]         r_link_kind;
    logic [15:0]        r_rotation_turns, r_radius_ratio, r_base_angle, r_angle_step;
    logic [14:0]        r_fixed_radius;
    logic signed [15:0] r_ref_x, r_ref_y;

    logic        w_adv;
    logic [15:0] w_den;

    assign pready = 1'b1;
    assign w_den  = (r_radius_ratio == 16'd0) ? 16'd1 : r_radius_ratio;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_link_kind      <= KIND_INDEP;
            r_rotation_turns <= 16'd0;
            r_radius_ratio   <= 16'd256;
            r_fixed_radius   <= 15'd16384;
            r_base_angle     <= 16'd0;
            r_angle_step     <= 16'd8192;
            r_ref_x          <= 16'sd0;
            r_ref_y          <= 16'sd0;
        end else if (psel && penable && pwrite) begin
            case (paddr[4:2])
                REG_LINK_KIND:  r_link_kind      <= pwdata[2:0];
                REG_ROTATION:   r_rotation_turns <= pwdata[15:0];
                REG_RATIO:      r_radius_ratio   <= pwdata[15:0];
                REG_FIX_RADIUS: r_fixed_radius   <= pwdata[14:0];
                REG_BASE_ANGLE: r_base_angle     <= pwdata[15:0];
                REG_ANGLE_STEP: r_angle_step     <= pwdata[15:0];
                REG_REF_X:      r_ref_x          <= pwdata[15:0];
                REG_REF_Y:      r_ref_y          <= pwdata[15:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (paddr[4:2])
            REG_LINK_KIND:  prdata = {29'd0, r_link_kind};
            REG_ROTATION:   prdata = {16'd0, r_rotation_turns};
            REG_RATIO:      prdata = {16'd0, r_radius_ratio};
            REG_FIX_RADIUS: prdata = {17'd0, r_fixed_radius};
            REG_BASE_ANGLE: prdata = {16'd0, r_base_angle};
            REG_ANGLE_STEP: prdata = {16'd0, r_angle_step};
            REG_REF_X:      prdata = {16'd0, r_ref_x};
            REG_REF_Y:      prdata = {16'd0, r_ref_y};
            default:        prdata = 32'd0;
        endcase
    end

    // Flow control: every stage moves together unless the output register is held.
    logic r_out_valid;
    assign w_adv   = !(r_out_valid && i_stall);
    assign o_stall = !w_adv;

    // Vectoring chain entry: fold the left half plane onto the right.
    logic signed [VW-1:0] w_in_x, w_in_y;
    t_vec w_vec  [0:CORDIC_STAGES];
    t_ctx w_vctx [0:CORDIC_STAGES];
    logic w_vval [0:CORDIC_STAGES];

    always_comb begin
        w_in_x = $signed({i_pos_x, 8'd0});
        w_in_y = $signed({i_pos_y, 8'd0});
        w_vec[0].zero = (i_pos_x == 16'sd0) && (i_pos_y == 16'sd0);
        if (w_in_x < 0) begin
            w_vec[0].x = -w_in_x;
            w_vec[0].y = -w_in_y;
            w_vec[0].z = HALF_TURN;
        end else begin
            w_vec[0].x = w_in_x;
            w_vec[0].y = w_in_y;
            w_vec[0].z = '0;
        end
        w_vctx[0].inv  = i_mode;
        w_vctx[0].px   = i_pos_x;
        w_vctx[0].py   = i_pos_y;
        w_vctx[0].rank = i_slot_rank;
        w_vval[0]      = i_valid;
    end

    genvar gi;
    generate
        for (gi = 0; gi < CORDIC_STAGES; gi++) begin : g_vec
            ppl_vec_cell #(.IDX(gi)) u_cell (
                .i_clk   (i_clk),
                .i_rst_n (i_rst_n),
                .i_adv   (w_adv),
                .i_valid (w_vval[gi]),
                .i_vec   (w_vec[gi]),
                .i_ctx   (w_vctx[gi]),
                .o_valid (w_vval[gi+1]),
                .o_vec   (w_vec[gi+1]),
                .o_ctx   (w_vctx[gi+1])
            );
        end
    endgenerate

    // Magnitude gain correction.
    logic signed [VW+30:0] w_g_prod;
    logic signed [VW+30:0] w_g_sum;
    logic signed [VW-1:0]  w_g_x;
    logic                  r_g_valid;
    logic signed [VW-1:0]  r_g_mag;
    logic [AW-1:0]         r_g_ang;
    t_ctx                  r_g_ctx;

    always_comb begin
        w_g_x    = w_vec[CORDIC_STAGES].x;
        w_g_prod = w_g_x * $signed({1'b0, INV_GAIN});
        w_g_sum  = w_g_prod + (VW+31)'(1 << 29);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_g_valid <= 1'b0;
        end else if (w_adv) begin
            r_g_valid <= w_vval[CORDIC_STAGES];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_g_mag <= w_g_sum[30 +: VW];
            r_g_ang <= w_vec[CORDIC_STAGES].zero ? '0 : w_vec[CORDIC_STAGES].z;
            r_g_ctx <= w_vctx[CORDIC_STAGES];
        end
    end

    // Ratio multiply and divider operands.
    logic signed [VW+17:0] w_m_prod, w_m_sum;
    logic [16:0]           w_abs_x, w_abs_y;
    t_div  w_div  [0:DW];
    t_side w_side [0:DW];
    logic  w_dval [0:DW];

    always_comb begin
        w_m_prod = r_g_mag * $signed({1'b0, w_den});
        w_m_sum  = w_m_prod + (VW+18)'(128);
        w_abs_x  = r_g_ctx.px[15] ? 17'(-$signed({r_g_ctx.px[15], r_g_ctx.px}))
                                  : {1'b0, r_g_ctx.px};
        w_abs_y  = r_g_ctx.py[15] ? 17'(-$signed({r_g_ctx.py[15], r_g_ctx.py}))
                                  : {1'b0, r_g_ctx.py};
        if (r_link_kind == KIND_CIRCULAR) begin
            w_div[0].na = {w_abs_x[15:0], 16'd0};
            w_div[0].sa = r_g_ctx.px[15];
        end else begin
            w_div[0].na = {r_g_mag[23:0], 8'd0};
            w_div[0].sa = 1'b0;
        end
        w_div[0].nb      = {w_abs_y[15:0], 16'd0};
        w_div[0].sb      = r_g_ctx.py[15];
        w_div[0].ra      = 16'd0;
        w_div[0].rb      = 16'd0;
        w_side[0].ctx    = r_g_ctx;
        w_side[0].ang    = r_g_ang;
        w_side[0].mul    = w_m_sum[8 +: RW];
        w_dval[0]        = r_g_valid;
    end

    generate
        for (gi = 0; gi < DW; gi++) begin : g_div
            ppl_div_cell u_cell (
                .i_clk   (i_clk),
                .i_rst_n (i_rst_n),
                .i_adv   (w_adv),
                .i_den   (w_den),
                .i_valid (w_dval[gi]),
                .i_div   (w_div[gi]),
                .i_side  (w_side[gi]),
                .o_valid (w_dval[gi+1]),
                .o_div   (w_div[gi+1]),
                .o_side  (w_side[gi+1])
            );
        end
    endgenerate

    // Select the rotation operands for the link kind, then fold to a quarter turn.
    t_side                w_ps;
    logic signed [RW-1:0] w_qa, w_qb, w_qa_mag, w_qb_mag, w_px_w, w_py_w, w_fr_w;
    logic signed [RW-1:0] w_rx, w_ry;
    logic [AW-1:0]        w_rot_ang, w_rank_ang, w_ang;
    logic signed [AW-1:0] w_z;
    logic [2:0]           w_rank;
    logic [15:0]          w_rang;
    logic signed [17:0]   w_px18, w_py18, w_rx18, w_ry18;
    t_rot  w_rot  [0:CORDIC_STAGES];
    t_post w_post [0:CORDIC_STAGES];
    logic  w_rval [0:CORDIC_STAGES];

    always_comb begin
        w_ps       = w_side[DW];
        w_qa_mag   = $signed({{(RW-DW){1'b0}}, w_div[DW].na});
        w_qb_mag   = $signed({{(RW-DW){1'b0}}, w_div[DW].nb});
        w_qa       = w_div[DW].sa ? -w_qa_mag : w_qa_mag;
        w_qb       = w_div[DW].sb ? -w_qb_mag : w_qb_mag;
        w_px_w     = $signed({w_ps.ctx.px, 8'd0});
        w_py_w     = $signed({w_ps.ctx.py, 8'd0});
        w_fr_w     = $signed({{(RW-23){1'b0}}, r_fixed_radius, 8'd0});
        w_rot_ang  = {r_rotation_turns, 16'd0};
        w_rank     = (w_ps.ctx.rank >= MAX_SOURCES) ? 3'(MAX_SOURCES - 1) : w_ps.ctx.rank;
        w_rang     = r_base_angle + 16'(r_angle_step * w_rank);
        w_rank_ang = {w_rang, 16'd0};
        w_px18     = w_ps.ctx.px;
        w_py18     = w_ps.ctx.py;
        w_rx18     = r_ref_x;
        w_ry18     = r_ref_y;

        w_rx = '0;
        w_ry = '0;
        w_ang = '0;
        w_post[0].direct = 1'b0;
        w_post[0].pmul   = 1'b0;
        w_post[0].dx     = w_px18;
        w_post[0].dy     = w_py18;
        case (r_link_kind)
            KIND_CIRCULAR: begin
                if (w_ps.ctx.inv) begin
                    w_rx  = w_qa;
                    w_ry  = w_qb;
                    w_ang = -w_rot_ang;
                end else begin
                    w_rx  = w_px_w;
                    w_ry  = w_py_w;
                    w_ang = w_rot_ang;
                    w_post[0].pmul = 1'b1;
                end
            end
            KIND_FIX_RAD: begin
                w_rx  = w_fr_w;
                w_ang = w_ps.ctx.inv ? w_ps.ang - w_rot_ang : w_ps.ang + w_rot_ang;
            end
            KIND_FIX_ANG: begin
                if (w_ps.ctx.inv) begin
                    w_rx  = w_qa;
                    w_ang = w_ps.ang - w_rot_ang;
                end else begin
                    w_rx  = w_ps.mul;
                    w_ang = w_rank_ang;
                end
            end
            KIND_FIXED: begin
                w_rx  = w_fr_w;
                w_ang = w_ps.ctx.inv ? w_ps.ang - w_rot_ang : w_rank_ang;
            end
            KIND_MIRROR_X: begin
                w_post[0].direct = 1'b1;
                if (!w_ps.ctx.inv) begin
                    w_post[0].dx = w_rx18;
                    w_post[0].dy = -w_ry18;
                end
            end
            KIND_MIRROR_Y: begin
                w_post[0].direct = 1'b1;
                if (!w_ps.ctx.inv) begin
                    w_post[0].dx = -w_rx18;
                    w_post[0].dy = w_ry18;
                end
            end
            KIND_DELTA: begin
                w_post[0].direct = 1'b1;
                if (!w_ps.ctx.inv) begin
                    w_post[0].dx = w_px18 + w_rx18;
                    w_post[0].dy = w_py18 + w_ry18;
                end else begin
                    w_post[0].dx = w_px18 - w_rx18;
                    w_post[0].dy = w_py18 - w_ry18;
                end
            end
            default: begin
                w_post[0].direct = 1'b1;
            end
        endcase

        w_z = $signed(w_ang);
        if (w_z > QUARTER_TURN) begin
            w_rot[0].x = -w_ry;
            w_rot[0].y = w_rx;
            w_rot[0].z = w_z - QUARTER_TURN;
        end else if (w_z < -QUARTER_TURN) begin
            w_rot[0].x = w_ry;
            w_rot[0].y = -w_rx;
            w_rot[0].z = w_z + QUARTER_TURN;
        end else begin
            w_rot[0].x = w_rx;
            w_rot[0].y = w_ry;
            w_rot[0].z = w_z;
        end
        w_rval[0] = w_dval[DW];
    end

    generate
        for (gi = 0; gi < CORDIC_STAGES; gi++) begin : g_rot
            ppl_rot_cell #(.IDX(gi)) u_cell (
                .i_clk   (i_clk),
                .i_rst_n (i_rst_n),
                .i_adv   (w_adv),
                .i_valid (w_rval[gi]),
                .i_rot   (w_rot[gi]),
                .i_post  (w_post[gi]),
                .o_valid (w_rval[gi+1]),
                .o_rot   (w_rot[gi+1]),
                .o_post  (w_post[gi+1])
            );
        end
    endgenerate

    // Gain correction of the rotated vector, split into two partial products.
    logic signed [RW-1:0] w_h_x, w_h_y;
    logic                 r_h_valid;
    logic signed [48:0]   r_h_xhi, r_h_yhi;
    logic [47:0]          r_h_xlo, r_h_ylo;
    t_post                r_h_post;

    assign w_h_x = w_rot[CORDIC_STAGES].x;
    assign w_h_y = w_rot[CORDIC_STAGES].y;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_h_valid <= 1'b0;
        end else if (w_adv) begin
            r_h_valid <= w_rval[CORDIC_STAGES];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_h_xhi  <= $signed(w_h_x[RW-1:18]) * $signed({1'b0, INV_GAIN});
            r_h_yhi  <= $signed(w_h_y[RW-1:18]) * $signed({1'b0, INV_GAIN});
            r_h_xlo  <= 48'(w_h_x[17:0]) * 48'(INV_GAIN);
            r_h_ylo  <= 48'(w_h_y[17:0]) * 48'(INV_GAIN);
            r_h_post <= w_post[CORDIC_STAGES];
        end
    end

    logic signed [67:0]   w_k_xhi, w_k_yhi, w_k_xs, w_k_ys;
    logic                 r_k_valid;
    logic signed [RW-1:0] r_k_x, r_k_y;
    t_post                r_k_post;

    always_comb begin
        w_k_xhi = r_h_xhi;
        w_k_yhi = r_h_yhi;
        w_k_xs  = (w_k_xhi <<< 18) + $signed({20'd0, r_h_xlo}) + 68'sd536870912;
        w_k_ys  = (w_k_yhi <<< 18) + $signed({20'd0, r_h_ylo}) + 68'sd536870912;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_k_valid <= 1'b0;
        end else if (w_adv) begin
            r_k_valid <= r_h_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_k_x    <= w_k_xs[30 +: RW];
            r_k_y    <= w_k_ys[30 +: RW];
            r_k_post <= r_h_post;
        end
    end

    // Radius scaling after a forward circular rotation, or the direct kinds.
    logic signed [42:0]   w_w_xp, w_w_yp;
    logic signed [FW-1:0] n_w_x, n_w_y;
    logic                 r_w_valid;
    logic signed [FW-1:0] r_w_x, r_w_y;

    always_comb begin
        w_w_xp = $signed(r_k_x[25:0]) * $signed({1'b0, w_den}) + 43'sd128;
        w_w_yp = $signed(r_k_y[25:0]) * $signed({1'b0, w_den}) + 43'sd128;
        if (r_k_post.direct) begin
            n_w_x = $signed({r_k_post.dx, 8'd0});
            n_w_y = $signed({r_k_post.dy, 8'd0});
        end else if (r_k_post.pmul) begin
            n_w_x = $signed(w_w_xp[42:8]);
            n_w_y = $signed(w_w_yp[42:8]);
        end else begin
            n_w_x = r_k_x;
            n_w_y = r_k_y;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_w_valid <= 1'b0;
        end else if (w_adv) begin
            r_w_valid <= r_k_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_w_x <= n_w_x;
            r_w_y <= n_w_y;
        end
    end

    // Round to Q2.14 and saturate.
    logic signed [FW:0] w_o_x, w_o_y, w_o_xr, w_o_yr;
    logic               w_x_hi, w_x_lo, w_y_hi, w_y_lo;
    logic signed [15:0] n_out_x, n_out_y;
    logic signed [15:0] r_out_x, r_out_y;
    logic               r_out_clip;

    always_comb begin
        w_o_x  = r_w_x;
        w_o_y  = r_w_y;
        w_o_xr = (w_o_x + (FW+1)'(128)) >>> 8;
        w_o_yr = (w_o_y + (FW+1)'(128)) >>> 8;
        w_x_hi = w_o_xr > 32767;
        w_x_lo = w_o_xr < -32768;
        w_y_hi = w_o_yr > 32767;
        w_y_lo = w_o_yr < -32768;
        n_out_x = w_x_hi ? 16'sh7FFF : (w_x_lo ? 16'sh8000 : w_o_xr[15:0]);
        n_out_y = w_y_hi ? 16'sh7FFF : (w_y_lo ? 16'sh8000 : w_o_yr[15:0]);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_adv) begin
            r_out_valid <= r_w_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_out_x    <= n_out_x;
            r_out_y    <= n_out_y;
            r_out_clip <= w_x_hi || w_x_lo || w_y_hi || w_y_lo;
        end
    end

    assign o_valid   = r_out_valid;
    assign o_out_x   = r_out_x;
    assign o_out_y   = r_out_y;
    assign o_clipped = r_out_clip;

    a_stall_only_when_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_out_valid |-> !o_stall)
        else $error("input stalled while the output register is empty");

    a_clip_at_limit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_clip) |->
            (r_out_x == 16'sh7FFF || r_out_x == 16'sh8000 ||
             r_out_y == 16'sh7FFF || r_out_y == 16'sh8000))
        else $error("clip flag raised without a saturated coordinate");

    a_indep_no_clip: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_link_kind == KIND_INDEP) |-> !r_out_clip)
        else $error("pass-through transaction reported saturation");

    a_held_output: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(r_out_valid && i_stall) |-> (r_out_valid && $stable(r_out_x) &&
            $stable(r_out_y) && $stable(r_out_clip)))
        else $error("stalled result changed");

    a_den_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_den != 16'd0)
        else $error("divider denominator is zero");

endmodule
